### hdl/lmcr_pkg.sv
package lmcr_pkg;

  localparam int unsigned ModulesDefault = 4;
  localparam int unsigned MaxModules     = 4;
  localparam int unsigned NumCols        = 8;
  localparam int unsigned ColIdxW        = 3;
  localparam int unsigned RowIdxW        = 5;
  localparam int unsigned CntW           = 3;
  localparam int unsigned WordW          = 64;
  localparam int unsigned BrightW        = 4;
  localparam int unsigned ScanW          = 3;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 4;
  localparam int unsigned QDepth         = 2;
  localparam int unsigned QPtrW          = 1;
  localparam int unsigned QCntW          = 2;

  localparam logic [CfgIdxW-1:0] CfgBrightness = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScanDigits = 2'd1;

  localparam logic [BrightW-1:0] BrightReset = 4'd1;
  localparam logic [ScanW-1:0]   ScanReset   = 3'd7;

  localparam logic [7:0] RegDisplayTest = 8'h0F;
  localparam logic [7:0] RegScanLimit   = 8'h0B;
  localparam logic [7:0] RegDecodeMode  = 8'h09;
  localparam logic [7:0] RegIntensity   = 8'h0A;
  localparam logic [7:0] RegShutdown    = 8'h0C;

  localparam logic [CntW-1:0] LastCol  = 3'd7;
  localparam logic [CntW-1:0] LastInit = 3'd4;

  typedef enum logic [1:0] {
    OpSetPixel  = 2'd0,
    OpDraw      = 2'd1,
    OpInit      = 2'd2,
    OpClearDraw = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e              op;
    logic [ColIdxW-1:0]   col;
    logic [RowIdxW-1:0]   row;
    logic                 val;
  } cmd_t;

  typedef struct packed {
    logic            draw_run;
    logic            init_run;
    logic [CntW-1:0] cnt;
  } back_status_t;

  function automatic logic [15:0] init_pair(input logic [CntW-1:0] idx,
                                            input logic [BrightW-1:0] bright,
                                            input logic [ScanW-1:0] scan);
    logic [15:0] pair;
    case (idx)
      3'd0:    pair = {RegDisplayTest, 8'h00};
      3'd1:    pair = {RegScanLimit, 5'd0, scan};
      3'd2:    pair = {RegDecodeMode, 8'h00};
      3'd3:    pair = {RegIntensity, 4'd0, bright};
      3'd4:    pair = {RegShutdown, 8'h01};
      default: pair = 16'h0000;
    endcase
    return pair;
  endfunction

endpackage

### hdl/lmcr_if.sv
interface lmcr_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] column;
  logic [5:0] row;
  logic       pixel_value;

  modport source(output valid, opcode, column, row, pixel_value, input ready);
  modport sink(input valid, opcode, column, row, pixel_value, output ready);
endinterface

interface lmcr_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_word;
  logic        last;

  modport source(output valid, frame_word, last, input ready);
  modport sink(input valid, frame_word, last, output ready);
endinterface

interface lmcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hdl/led_matrix_cascade_refresher.sv
// Frame buffer and latch-word generator for a chain of MODULES 8x8 LED driver chips.
// A pixel write is first stored in the command queue and lands in the buffer when the
// word generator fetches it, later when earlier commands are still queued or running.
// A draw produces eight words, one per buffer column, at one word per cycle when the
// output side is ready, after the command fetch from the queue; the init sequence
// produces five words in the same way. Commands wait in a two-entry queue in front
// of the word generator, so input transfers continue while a draw is still running,
// until the queue is full. Each word is right aligned in 16*MODULES bits, and
// the final word of a run carries last. Configuration writes are taken at any time
// but should only be issued while the block is idle.
module led_matrix_cascade_refresher #(
  parameter int unsigned MODULES = lmcr_pkg::ModulesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmcr_cmd_if.sink    in_ch,
  lmcr_word_if.source out_ch,
  lmcr_cfg_if.sink    cfg_ch
);

  logic                          push;
  logic                          pop;
  logic                          full;
  logic                          empty;
  lmcr_pkg::cmd_t                cmd;
  lmcr_pkg::cmd_t                head;
  lmcr_pkg::back_status_t        status;
  logic [lmcr_pkg::BrightW-1:0]  bright_q;
  logic [lmcr_pkg::ScanW-1:0]    scan_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= lmcr_pkg::BrightReset;
      scan_q   <= lmcr_pkg::ScanReset;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == lmcr_pkg::CfgBrightness) begin
        bright_q <= cfg_ch.data[lmcr_pkg::BrightW-1:0];
      end else if (cfg_ch.index == lmcr_pkg::CfgScanDigits) begin
        scan_q <= cfg_ch.data[lmcr_pkg::ScanW-1:0];
      end
    end
  end

  lmcr_front #(.MODULES(MODULES)) u_front (
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  lmcr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  lmcr_back #(.MODULES(MODULES)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head),
    .bright_i (bright_q),
    .scan_i   (scan_q),
    .pop_o    (pop),
    .status_o (status),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_init_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.init_run |-> status.cnt <= lmcr_pkg::LastInit)
    else $error("init counter past the last init word");

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.last |->
      out_ch.frame_word[15:8] == 8'h08 || out_ch.frame_word[15:8] == lmcr_pkg::RegShutdown)
    else $error("last marks a word that does not end a run");

  a_draw_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.draw_run && out_ch.valid && !out_ch.ready |=> status.draw_run)
    else $error("draw left its state while the output was stalled");
`endif

endmodule

### hdl/lmcr_front.sv
module lmcr_front #(
  parameter int unsigned MODULES = lmcr_pkg::ModulesDefault
) (
  lmcr_cmd_if.sink         in_ch,
  input  logic             full_i,
  output logic             push_o,
  output lmcr_pkg::cmd_t   cmd_o
);

  localparam logic [5:0] MaxRow = 6'(8 * MODULES);

  lmcr_pkg::opcode_e op;
  logic              in_range;
  logic [3:0]        col_m1;
  logic [5:0]        row_m1;

  assign op     = lmcr_pkg::opcode_e'(in_ch.opcode);
  assign col_m1 = in_ch.column - 4'd1;
  assign row_m1 = in_ch.row - 6'd1;

  assign in_range = (in_ch.column >= 4'd1) && (in_ch.column <= 4'd8) &&
                    (in_ch.row >= 6'd1) && (in_ch.row <= MaxRow);

  assign in_ch.ready = !full_i;

  // Pixel writes that fall outside the matrix are dropped here.
  assign push_o = in_ch.valid && in_ch.ready &&
                  ((op != lmcr_pkg::OpSetPixel) || in_range);

  assign cmd_o.op  = op;
  assign cmd_o.col = col_m1[lmcr_pkg::ColIdxW-1:0];
  assign cmd_o.row = row_m1[lmcr_pkg::RowIdxW-1:0];
  assign cmd_o.val = in_ch.pixel_value;

endmodule

### hdl/lmcr_fifo.sv
module lmcr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lmcr_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output lmcr_pkg::cmd_t head_o
);

  lmcr_pkg::cmd_t                     mem_q [lmcr_pkg::QDepth];
  logic [lmcr_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [lmcr_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [lmcr_pkg::QCntW-1:0]         cnt_q, cnt_d;

  assign full_o  = (cnt_q == lmcr_pkg::QCntW'(lmcr_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### hdl/lmcr_back.sv
module lmcr_back #(
  parameter int unsigned MODULES = lmcr_pkg::ModulesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  lmcr_pkg::cmd_t                head_i,
  input  logic [lmcr_pkg::BrightW-1:0]  bright_i,
  input  logic [lmcr_pkg::ScanW-1:0]    scan_i,
  output logic                          pop_o,
  output lmcr_pkg::back_status_t        status_o,
  lmcr_word_if.source                   out_ch
);

  localparam int unsigned BufW = 8 * MODULES;
  localparam int unsigned RowW = $clog2(BufW);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDraw = 3'b010,
    StInit = 3'b100
  } state_e;

  state_e                           state_q, state_d;
  logic [lmcr_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [BufW-1:0]                  fb_q [lmcr_pkg::NumCols];
  logic [BufW-1:0]                  fb_d [lmcr_pkg::NumCols];
  logic                             out_valid_q, out_valid_d;
  logic [lmcr_pkg::WordW-1:0]       word_q, word_d;
  logic                             last_q, last_d;
  logic [lmcr_pkg::WordW-1:0]       draw_word;
  logic [lmcr_pkg::WordW-1:0]       init_word;
  logic [7:0]                       col_addr;
  logic [15:0]                      pair;
  logic                             can_load;

  assign col_addr = {5'd0, cnt_q} + 8'd1;
  assign pair     = lmcr_pkg::init_pair(cnt_q, bright_i, scan_i);

  for (genvar m = 0; m < lmcr_pkg::MaxModules; m++) begin : g_mod
    if (m < MODULES) begin : g_used
      assign draw_word[16*m +: 16] = {col_addr, fb_q[cnt_q][8*m +: 8]};
      assign init_word[16*m +: 16] = pair;
    end else begin : g_unused
      assign draw_word[16*m +: 16] = 16'h0000;
      assign init_word[16*m +: 16] = 16'h0000;
    end
  end

  assign can_load = !out_valid_q || out_ch.ready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fb_d        = fb_q;
    word_d      = word_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    pop_o       = 1'b0;
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cnt_d = '0;
          case (head_i.op)
            lmcr_pkg::OpSetPixel: begin
              fb_d[head_i.col][head_i.row[RowW-1:0]] = head_i.val;
            end
            lmcr_pkg::OpDraw: begin
              state_d = StDraw;
            end
            lmcr_pkg::OpInit: begin
              state_d = StInit;
            end
            lmcr_pkg::OpClearDraw: begin
              for (int c = 0; c < lmcr_pkg::NumCols; c++) begin
                fb_d[c] = '0;
              end
              state_d = StDraw;
            end
            default: begin
            end
          endcase
        end
      end
      StDraw: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          word_d      = draw_word;
          last_d      = (cnt_q == lmcr_pkg::LastCol);
          cnt_d       = cnt_q + 3'd1;
          if (cnt_q == lmcr_pkg::LastCol) begin
            state_d = StIdle;
          end
        end
      end
      StInit: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          word_d      = init_word;
          last_d      = (cnt_q == lmcr_pkg::LastInit);
          cnt_d       = cnt_q + 3'd1;
          if (cnt_q == lmcr_pkg::LastInit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < lmcr_pkg::NumCols; c++) begin
        fb_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      fb_q        <= fb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    last_q <= last_d;
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.frame_word = word_q;
  assign out_ch.last       = last_q;

  assign status_o.draw_run = (state_q == StDraw);
  assign status_o.init_run = (state_q == StInit);
  assign status_o.cnt      = cnt_q;

endmodule
